// ----- rtl/mps_pkg.sv -----
// ----------------------------------------------------------------------------
// mps_pkg: shared types and constants of the Markov password scorer
// Holds the operation codes, the command format of the front-to-back queue,
// the read beat from the table stage to the execute stage, and the cost and
// index constants.
// ----------------------------------------------------------------------------
`default_nettype none

package mps_pkg;

	localparam logic [1:0] OP_UNI = 2'd0;
	localparam logic [1:0] OP_BI = 2'd1;
	localparam logic [1:0] OP_PW = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [7:0] UNKNOWN_COST = 8'd255;
	localparam logic [7:0] UNASSIGNED = 8'd255;
	localparam int unsigned MAX_WORD_LEN = 4095;
	localparam int unsigned COUNT_LIMIT = 4095;
	localparam int unsigned COUNT_CAP_INT = (MAX_WORD_LEN > COUNT_LIMIT) ? COUNT_LIMIT :
		((MAX_WORD_LEN < 1) ? 1 : MAX_WORD_LEN);
	localparam logic [11:0] COUNT_CAP = 12'(COUNT_CAP_INT);
	localparam bit THIRD_OK = (COUNT_CAP_INT > 2);
	localparam logic [19:0] SUM_MAX = 20'hFFFFF;
	localparam logic [62:0] INDEX_LIMIT = 63'd8000000000000000000;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	typedef enum logic [1:0] {
		KIND_UNI,
		KIND_BI,
		KIND_PW
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] prev_byte;
		logic [7:0] cur_byte;
		logic [7:0] cost;
		logic       word_end;
	} cmd_t;

	typedef struct packed {
		logic       word_end;
		logic [8:0] cs;
		logic [7:0] uni_data;
		logic       uni_ok;
		logic [7:0] bi_data;
		logic [7:0] pos_data;
		logic       pos_ok;
	} rd_t;

endpackage

`default_nettype wire

// ----- rtl/mps_front.sv -----
// ----------------------------------------------------------------------------
// mps_front: input acceptance and classification
// Takes input beats, turns the operation code into a command kind, drops
// unused codes, and pushes the command into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mps_front (
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      op,
	input  logic [7:0]      prev_byte,
	input  logic [7:0]      cur_byte,
	input  logic [7:0]      cost,
	input  logic            word_end,
	input  logic            busy,
	output logic            push_valid,
	input  logic            push_ready,
	output mps_pkg::cmd_t   push_data
);
	import mps_pkg::*;

	logic  keep;
	kind_t kind;

	always_comb begin
		keep = 1'b1;
		kind = KIND_PW;
		unique case (op)
			OP_UNI: kind = KIND_UNI;
			OP_BI:  kind = KIND_BI;
			OP_PW:  kind = KIND_PW;
			default: keep = 1'b0;
		endcase
	end

	assign in_ready = !busy && push_ready;
	assign push_valid = in_valid && in_ready && keep;
	assign push_data = '{kind: kind, prev_byte: prev_byte, cur_byte: cur_byte,
		cost: cost, word_end: word_end};

endmodule

`default_nettype wire

// ----- rtl/mps_queue.sv -----
// ----------------------------------------------------------------------------
// mps_queue: command queue between front and back
// A small register queue that lets the front keep accepting while the back
// waits on its output, and the other way round.
// ----------------------------------------------------------------------------
`default_nettype none

module mps_queue #(
	parameter int unsigned Depth = mps_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  mps_pkg::cmd_t   push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output mps_pkg::cmd_t   pop_data
);
	import mps_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	cmd_t            slot_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != CntW'(Depth));
	assign pop_valid = (count_q != '0);
	assign pop_data = slot_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/mps_tables.sv -----
// ----------------------------------------------------------------------------
// mps_tables: cost tables, charset positions and table read stage
// Carries out load commands, clears the bigram table after reset, and reads
// the unigram, bigram and position entries of each password byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mps_tables (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  mps_pkg::cmd_t   pop_data,
	output logic            busy,
	output logic            rd_valid,
	input  logic            rd_ready,
	output mps_pkg::rd_t    rd
);
	import mps_pkg::*;

	localparam logic [8:0] CHARSET_LAST = 9'd255;
	localparam logic [8:0] CHARSET_OVER = 9'd256;

	logic [7:0]  uni_mem [256];
	logic [7:0]  bi_mem [65536];
	logic [7:0]  pos_mem [256];
	logic [255:0] uni_vld_q;
	logic [255:0] asgn_q;
	logic [8:0]  cs_q;
	logic [7:0]  last_q;
	logic        clr_busy_q;
	logic [15:0] clr_addr_q;
	logic        valid_s1;

	logic [7:0]  uni_data_s1;
	logic        uni_ok_s1;
	logic [7:0]  bi_data_s1;
	logic [7:0]  pos_data_s1;
	logic        pos_ok_s1;
	logic [8:0]  cs_s1;
	logic        word_end_s1;

	logic        is_load;
	logic        s1_free;
	logic        issue;
	logic        issue_pw;
	logic        issue_uni;
	logic        issue_bi;
	logic        new_byte;
	logic        pos_we;
	logic        bi_we;
	logic [15:0] bi_waddr;
	logic [7:0]  bi_wdata;

	assign is_load = (pop_data.kind != KIND_PW);
	assign s1_free = !valid_s1 || rd_ready;
	assign pop_ready = !clr_busy_q && (is_load || s1_free);
	assign issue = pop_valid && pop_ready;
	assign issue_pw = issue && (pop_data.kind == KIND_PW);
	assign issue_uni = issue && (pop_data.kind == KIND_UNI);
	assign issue_bi = issue && (pop_data.kind == KIND_BI);
	assign new_byte = issue && is_load && !asgn_q[pop_data.cur_byte];
	assign pos_we = new_byte && (cs_q < CHARSET_LAST);
	assign busy = clr_busy_q;

	assign bi_we = clr_busy_q || issue_bi;
	assign bi_waddr = clr_busy_q ? clr_addr_q : {pop_data.prev_byte, pop_data.cur_byte};
	assign bi_wdata = clr_busy_q ? UNKNOWN_COST : pop_data.cost;

	always_ff @(posedge clk) begin
		if (issue_uni) begin
			uni_mem[pop_data.cur_byte] <= pop_data.cost;
		end
		if (issue_pw) begin
			uni_data_s1 <= uni_mem[pop_data.cur_byte];
		end
	end

	always_ff @(posedge clk) begin
		if (bi_we) begin
			bi_mem[bi_waddr] <= bi_wdata;
		end
		if (issue_pw) begin
			bi_data_s1 <= bi_mem[{last_q, pop_data.cur_byte}];
		end
	end

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[pop_data.cur_byte] <= cs_q[7:0];
		end
		if (issue_pw) begin
			pos_data_s1 <= pos_mem[pop_data.cur_byte];
		end
	end

	always_ff @(posedge clk) begin
		if (issue_pw) begin
			uni_ok_s1 <= uni_vld_q[pop_data.cur_byte];
			pos_ok_s1 <= asgn_q[pop_data.cur_byte];
			cs_s1 <= cs_q;
			word_end_s1 <= pop_data.word_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uni_vld_q <= '0;
			asgn_q <= '0;
			cs_q <= '0;
			last_q <= '0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 16'd1;
				if (clr_addr_q == '1) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (issue_uni) begin
				uni_vld_q[pop_data.cur_byte] <= 1'b1;
			end
			if (new_byte) begin
				if (cs_q < CHARSET_LAST) begin
					asgn_q[pop_data.cur_byte] <= 1'b1;
					cs_q <= cs_q + 9'd1;
				end else if (cs_q == CHARSET_LAST) begin
					cs_q <= CHARSET_OVER;
				end
			end
			if (issue_pw) begin
				last_q <= pop_data.word_end ? '0 : pop_data.cur_byte;
			end
			if (s1_free) begin
				valid_s1 <= issue_pw;
			end
		end
	end

	assign rd_valid = valid_s1;
	assign rd = '{word_end: word_end_s1, cs: cs_s1, uni_data: uni_data_s1,
		uni_ok: uni_ok_s1, bi_data: bi_data_s1, pos_data: pos_data_s1,
		pos_ok: pos_ok_s1};

endmodule

`default_nettype wire

// ----- rtl/mps_exec.sv -----
// ----------------------------------------------------------------------------
// mps_exec: per-password accumulation and result register
// Keeps the running sums, byte count and mixed-radix index of the current
// password and loads one result beat per password byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mps_exec (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_valid,
	output logic            rd_ready,
	input  mps_pkg::rd_t    rd,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      term,
	output logic [19:0]     total,
	output logic [11:0]     word_length,
	output logic [62:0]     rank_index,
	output logic            rank_valid,
	output logic [19:0]     tail_total,
	output logic            is_last
);
	import mps_pkg::*;

	logic [11:0] count_q;
	logic [19:0] sum_q;
	logic [19:0] tail_q;
	logic [62:0] idx_q;
	logic        bad_q;
	logic        out_valid_q;

	logic [7:0]  term_s2;
	logic [19:0] total_s2;
	logic [11:0] length_s2;
	logic [62:0] index_s2;
	logic        rank_ok_s2;
	logic [19:0] tail_s2;
	logic        last_s2;

	logic        fire;
	logic        first;
	logic        third;
	logic [7:0]  uni_term;
	logic [7:0]  pos;
	logic [7:0]  term_n;
	logic [20:0] sum_add;
	logic [20:0] tail_add;
	logic [19:0] sum_n;
	logic [19:0] tail_n;
	logic [11:0] count_n;
	logic [71:0] prod;
	logic [71:0] acc;
	logic        over;
	logic [62:0] idx_n;
	logic        bad_n;

	assign rd_ready = !out_valid_q || out_ready;
	assign fire = rd_valid && rd_ready;

	always_comb begin
		first = (count_q == '0);
		third = (count_q == 12'd2) && THIRD_OK;
		uni_term = rd.uni_ok ? rd.uni_data : UNKNOWN_COST;
		pos = rd.pos_ok ? rd.pos_data : UNASSIGNED;
		term_n = first ? uni_term : rd.bi_data;

		sum_add = {1'b0, sum_q} + 21'(term_n);
		tail_add = {1'b0, tail_q} + 21'(term_n);
		sum_n = first ? 20'(term_n) : (sum_add[20] ? SUM_MAX : sum_add[19:0]);
		if (first) begin
			tail_n = '0;
		end else if (third) begin
			tail_n = 20'(uni_term);
		end else if (tail_q != '0) begin
			tail_n = tail_add[20] ? SUM_MAX : tail_add[19:0];
		end else begin
			tail_n = tail_q;
		end

		if (first) begin
			count_n = 12'd1;
		end else if (count_q < COUNT_CAP) begin
			count_n = count_q + 12'd1;
		end else begin
			count_n = count_q;
		end

		prod = 72'(idx_q) * 72'(rd.cs);
		acc = prod + 72'(pos);
		over = (acc >= 72'(INDEX_LIMIT));
		idx_n = idx_q;
		bad_n = bad_q;
		if (first) begin
			idx_n = 63'(pos);
			bad_n = (pos == UNASSIGNED);
		end else if (!bad_q) begin
			if (pos == UNASSIGNED || over) begin
				bad_n = 1'b1;
			end else begin
				idx_n = acc[62:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			term_s2 <= term_n;
			total_s2 <= sum_n;
			length_s2 <= count_n;
			index_s2 <= bad_n ? '0 : idx_n;
			rank_ok_s2 <= !bad_n;
			tail_s2 <= tail_n;
			last_s2 <= rd.word_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q <= '0;
			tail_q <= '0;
			idx_q <= '0;
			bad_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_ready) begin
				out_valid_q <= rd_valid;
			end
			if (fire) begin
				if (rd.word_end) begin
					count_q <= '0;
					sum_q <= '0;
					tail_q <= '0;
					idx_q <= '0;
					bad_q <= 1'b0;
				end else begin
					count_q <= count_n;
					sum_q <= sum_n;
					tail_q <= tail_n;
					idx_q <= idx_n;
					bad_q <= bad_n;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign term = term_s2;
	assign total = total_s2;
	assign word_length = length_s2;
	assign rank_index = index_s2;
	assign rank_valid = rank_ok_s2;
	assign tail_total = tail_s2;
	assign is_last = last_s2;

endmodule

`default_nettype wire

// ----- rtl/markov_password_scorer.sv -----
// ----------------------------------------------------------------------------
// markov_password_scorer: Markov cost and rank scorer for password bytes
// Loads unigram and bigram cost tables, then scores passwords one byte per
// beat with running costs and a mixed-radix rank over the loaded charset.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock cycle while in_ready is high, and
// gives one result beat per password byte; load beats give no result. A
// password byte's beat passes through the command queue register and the
// table read stage register, after which the execute stage, whose running
// index update (one multiply by the charset size, one add and one compare
// against the limit) sets the one-byte-per-cycle figure, loads the result
// register. After reset all 65536 bigram table entries are filled with the
// unknown cost in one pass, during which in_ready stays low.
`default_nettype none

module markov_password_scorer #(
	parameter int unsigned QueueDepth = mps_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  prev_byte,
	input  logic [7:0]  cur_byte,
	input  logic [7:0]  cost,
	input  logic        word_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  term,
	output logic [19:0] total,
	output logic [11:0] word_length,
	output logic [62:0] rank_index,
	output logic        rank_valid,
	output logic [19:0] tail_total,
	output logic        is_last
);
	import mps_pkg::*;

	logic busy;
	logic push_valid;
	logic push_ready;
	cmd_t push_data;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_data;
	logic rd_valid;
	logic rd_ready;
	rd_t  rd;

	mps_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.prev_byte  (prev_byte),
		.cur_byte   (cur_byte),
		.cost       (cost),
		.word_end   (word_end),
		.busy       (busy),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	mps_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	mps_tables u_tables (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.busy      (busy),
		.rd_valid  (rd_valid),
		.rd_ready  (rd_ready),
		.rd        (rd)
	);

	mps_exec u_exec (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_valid    (rd_valid),
		.rd_ready    (rd_ready),
		.rd          (rd),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.term        (term),
		.total       (total),
		.word_length (word_length),
		.rank_index  (rank_index),
		.rank_valid  (rank_valid),
		.tail_total  (tail_total),
		.is_last     (is_last)
	);

endmodule

`default_nettype wire

// ----- rtl/mps_checker.sv -----
// ----------------------------------------------------------------------------
// mps_checker: port-level checks of the Markov password scorer
// Watches the input and result channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module mps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  op,
	input logic [7:0]  prev_byte,
	input logic [7:0]  cur_byte,
	input logic [7:0]  cost,
	input logic        word_end,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  term,
	input logic [19:0] total,
	input logic [11:0] word_length,
	input logic [62:0] rank_index,
	input logic        rank_valid,
	input logic [19:0] tail_total,
	input logic        is_last
);
	import mps_pkg::*;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(op) && $stable(prev_byte)
			&& $stable(cur_byte) && $stable(cost) && $stable(word_end))
		else $error("input beat changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(term) && $stable(total)
			&& $stable(word_length) && $stable(rank_index) && $stable(rank_valid)
			&& $stable(tail_total) && $stable(is_last))
		else $error("result beat changed while stalled");

	a_rank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rank_valid |-> rank_index == '0)
		else $error("invalid rank carries a nonzero index");

	a_rank_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rank_valid |-> rank_index < INDEX_LIMIT)
		else $error("valid rank at or above the limit");

	a_first_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && word_length == 12'd1 |-> total == 20'(term) && tail_total == '0)
		else $error("first byte of a password has inconsistent sums");

endmodule

bind markov_password_scorer mps_checker u_checker (.*);

`default_nettype wire
